// ===== src/wbps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

   localparam int PatternBytes = 16;
   localparam int AddrWidth    = 64;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 64;
   localparam int LenRegWidth   = 5;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_PATTERN_LOW  = 3'd0,
      CSR_PATTERN_HIGH = 3'd1,
      CSR_CARE_MASK    = 3'd2,
      CSR_PATTERN_LEN  = 3'd3,
      CSR_REGION_BASE  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [8*PatternBytes-1:0] bytes;
      logic [PatternBytes-1:0]   care;
   } pattern_type;

   typedef struct packed {
      logic                 found;
      logic [AddrWidth-1:0] address;
   } rsp_item_type;

endpackage

// ===== src/wbps_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_cell
// One window byte: holds it, hands it to the next cell on each step, and
// checks the byte shifting in against the pattern position aligned to it.
// ----------------------------------------------------------------------------
module wbps_cell #(
   parameter int MAX_PATTERN_BYTES = 16,
   parameter int INDEX             = 0,
   parameter int LW                = $clog2(MAX_PATTERN_BYTES + 1)
) (
   input  logic                 clock,
   input  logic                 advance,
   input  logic [7:0]           byte_in,
   input  logic [LW-1:0]        len,
   input  wbps_pkg::pattern_type pattern,
   output logic [7:0]           byte_out,
   output logic                 hit
);
   import wbps_pkg::*;

   logic [7:0]    recent_ff;
   logic [7:0]    recent_in;
   logic [LW-1:0] pos;
   logic [3:0]    sel;
   logic          in_use;

   // position in the pattern that lands on this cell once the byte shifts in
   always_comb begin
      in_use = int'(len) > INDEX;
      pos    = len - LW'(INDEX + 1);
      sel    = 4'(pos);
      hit    = 1'b1;
      if (in_use && int'(pos) < PatternBytes && pattern.care[sel]) begin
         hit = (pattern.bytes[8*sel +: 8] == byte_in);
      end
      recent_in = advance ? byte_in : recent_ff;
   end

   always_ff @(posedge clock) begin
      recent_ff <= recent_in;
   end

   assign byte_out = recent_ff;

endmodule

// ===== src/wbps_rsp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_rsp_queue
// Two-entry result queue with registered outputs.
// ----------------------------------------------------------------------------
module wbps_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  wbps_pkg::rsp_item_type push_item,
   output logic                   space,
   output logic                   rsp_valid,
   output wbps_pkg::rsp_item_type rsp_item,
   input  logic                   rsp_ready
);
   import wbps_pkg::*;

   rsp_item_type q0_ff, q0_in, q1_ff, q1_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic [1:0]   level;
   logic         pop;

   always_comb begin
      pop   = (cnt_ff != 2'd0) && rsp_ready;
      q0_in = pop ? q1_ff : q0_ff;
      q1_in = q1_ff;
      level = cnt_ff - 2'(pop);
      if (push) begin
         if (level == 2'd0) begin
            q0_in = push_item;
         end else begin
            q1_in = push_item;
         end
      end
      cnt_in = level + 2'(push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   assign space     = (cnt_ff != 2'd2);
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_item  = q0_ff;

endmodule

// ===== src/wildcard_byte_pattern_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// Finds the first occurrence of a wildcard byte signature in a byte stream.
// ----------------------------------------------------------------------------
// Takes one region byte per clock cycle, back to back, as long as the two-entry
// result queue has room; the whole window compare is done in the accepting
// cycle by the row of byte cells, and the result (found with its address, or
// not found on the last byte) is registered in the queue and shown on rsp in order.
// Bytes after a match give nothing until the byte marked tlast restarts the
// scan. Registers may be written between transactions and apply to the next
// byte.
module wildcard_byte_pattern_scan #(
   parameter int MAX_PATTERN_BYTES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // data_byte
   input  logic                               req_tlast,  // last_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [63:0]                        rsp_tdata,  // match_address
   output logic                               rsp_tuser,  // found
   input  logic                               csr_we,
   input  logic [wbps_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [wbps_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import wbps_pkg::*;

   localparam int LW = $clog2(MAX_PATTERN_BYTES + 1);

   logic [63:0]            pat_low_ff, pat_high_ff, base_ff;
   logic [15:0]            care_ff;
   logic [LenRegWidth-1:0] plen_ff;

   logic [AddrWidth-1:0]   seen_ff, seen_in, seen_next;
   logic                   done_ff, done_in;

   logic [LW-1:0]          len;
   pattern_type            pattern;
   logic                   accept, advance, match, push, space;
   rsp_item_type           push_item, rsp_item;

   logic [7:0]                   chain [0:MAX_PATTERN_BYTES];
   logic [MAX_PATTERN_BYTES-1:0] hits;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         care_ff     <= '0;
         plen_ff     <= LenRegWidth'(1);
         base_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:  pat_low_ff  <= csr_wdata;
            CSR_PATTERN_HIGH: pat_high_ff <= csr_wdata;
            CSR_CARE_MASK:    care_ff     <= csr_wdata[15:0];
            CSR_PATTERN_LEN:  plen_ff     <= csr_wdata[LenRegWidth-1:0];
            CSR_REGION_BASE:  base_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (plen_ff == '0) begin
         len = LW'(1);
      end else if (int'(plen_ff) > MAX_PATTERN_BYTES) begin
         len = LW'(MAX_PATTERN_BYTES);
      end else begin
         len = LW'(plen_ff);
      end
   end

   assign pattern.bytes = {pat_high_ff, pat_low_ff};
   assign pattern.care  = care_ff;

   // window cells
   assign chain[0] = req_tdata;

   for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
      wbps_cell #(
         .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
         .INDEX             (k),
         .LW                (LW)
      ) u_cell (
         .clock    (clock),
         .advance  (advance),
         .byte_in  (chain[k]),
         .len      (len),
         .pattern  (pattern),
         .byte_out (chain[k+1]),
         .hit      (hits[k])
      );
   end

   // scan control
   always_comb begin
      accept    = req_tvalid && req_tready;
      advance   = accept && !done_ff;
      seen_next = seen_ff + 1'b1;
      match     = (&hits) && (seen_next >= AddrWidth'(len));

      seen_in   = seen_ff;
      done_in   = done_ff;
      push      = 1'b0;
      push_item.found   = 1'b0;
      push_item.address = '0;

      if (advance) begin
         seen_in = seen_next;
         if (match) begin
            push              = 1'b1;
            push_item.found   = 1'b1;
            push_item.address = base_ff + seen_next - AddrWidth'(len);
            done_in           = 1'b1;
         end else if (req_tlast) begin
            push = 1'b1;
         end
      end

      if (accept && req_tlast) begin
         seen_in = '0;
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         done_ff <= done_in;
      end
   end

   wbps_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .space     (space),
      .rsp_valid (rsp_tvalid),
      .rsp_item  (rsp_item),
      .rsp_ready (rsp_tready)
   );

   assign req_tready = space;
   assign rsp_tdata  = rsp_item.address;
   assign rsp_tuser  = rsp_item.found;

endmodule

// ===== src/wbps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_checker
// Port-level checks for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
module wbps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        csr_we,
   input logic [2:0]  csr_index,
   input logic [63:0] csr_wdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // not-found result carries a zero address
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 64'd0)
      else $error("not-found result with nonzero address");

   // queue empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // a result only follows an accepted byte
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result without an input transaction");

   // input back-pressure only while a result is pending
   a_ready_space: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty result queue");

endmodule

bind wildcard_byte_pattern_scan wbps_checker u_wbps_checker (.*);
